>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro takes its clock, reset and message as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rht_pkg.sv
// Shared types and constants for the reference-counted hash table.
// No dependencies; used by every module of the block.
`default_nettype none

package rht_pkg;

    localparam int BUCKETS    = 29;
    localparam int ENTRIES    = 256;
    localparam int COUNT_W    = 16;
    localparam int KEY_W      = 32;

    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int BKT_W      = $clog2(BUCKETS);
    localparam int REM_W      = BKT_W + 1;

    // Reciprocal for key % BUCKETS: quotient estimate is low by at most one.
    localparam int unsigned RECIP_SHIFT = $clog2(BUCKETS) - 1;
    localparam logic [KEY_W-1:0] BKT_RECIP =
        KEY_W'((64'd1 << (KEY_W + RECIP_SHIFT)) / BUCKETS);

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_REF   = 2'd1,
        KIND_FIND  = 2'd2,
        KIND_UNREF = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_BAD       = 3'd4
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [LINK_W-1:0]  next;
    } entry_word_t;

endpackage

`default_nettype wire

>>> design/rht_bucket.sv
// Bucket index unit: key % BUCKETS in two registered stages.
// Depends on rht_pkg (reciprocal constant and widths).
`default_nettype none

module rht_bucket (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rht_pkg::KEY_W-1:0]  key,
    output logic                       done,
    output logic [rht_pkg::BKT_W-1:0]  bucket
);
    import rht_pkg::*;

    logic [2*KEY_W-1:0] prod_reg;
    logic [REM_W-1:0]   key_low_reg;
    logic [REM_W-1:0]   q_low;
    logic [REM_W-1:0]   rem;
    logic [BKT_W-1:0]   bucket_next;
    logic [BKT_W-1:0]   bucket_reg;
    logic               stage1_reg;
    logic               stage2_reg;

    // Remainder is below twice BUCKETS, so the low bits suffice.
    assign q_low       = prod_reg[KEY_W + RECIP_SHIFT +: REM_W];
    assign rem         = key_low_reg - REM_W'(q_low * BUCKETS);
    assign bucket_next = (rem >= REM_W'(BUCKETS)) ? BKT_W'(rem - REM_W'(BUCKETS))
                                                  : BKT_W'(rem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= (2*KEY_W)'(key) * (2*KEY_W)'(BKT_RECIP);
        key_low_reg <= key[REM_W-1:0];
        bucket_reg  <= bucket_next;
    end

    assign done   = stage2_reg;
    assign bucket = bucket_reg;

endmodule

`default_nettype wire

>>> design/refcounted_hash_table_top.sv
// Top level of the reference-counted chained hash table.
// Depends on rht_pkg and rht_bucket.
//
// One request item in, one result item out. Alloc pops a free entry and puts
// it at the head of bucket key % 29 with count 1; find walks that bucket and
// bumps the count of the newest matching entry; ref bumps a live entry's
// count (saturating); unref drops it and, at zero, unlinks and frees the
// entry. Items are handled one at a time: ref and unref read the entry and
// write it back; alloc waits for the bucket index and then links the entry;
// find waits for the bucket index and then reads one chain entry per step;
// an unref that frees hashes its key and walks its bucket to the entry
// ahead of it. The entry memory gives one read a cycle, data registered;
// the bucket index unit has two stages. The next item is accepted while the
// previous result still waits in the output register. Entry key, count and
// link live in a single 256-deep memory; bucket heads and live flags are
// flops cleared by reset; never-pushed free stack slots use power-up order.
`default_nettype none

module refcounted_hash_table_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic [rht_pkg::KEY_W-1:0]    key,
    input  logic [rht_pkg::IDX_W-1:0]    handle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rht_pkg::IDX_W-1:0]    entry,
    output logic [2:0]                   status,
    output logic [rht_pkg::COUNT_W-1:0]  ref_count
);
    import rht_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_FIND,
        S_HREAD,
        S_UNHASH,
        S_UNLINK,
        S_DONE
    } state_t;

    // Control and request registers
    state_t             state_reg,     state_next;
    kind_t              kind_reg,      kind_next;
    logic [KEY_W-1:0]   key_reg,       key_next;
    logic [IDX_W-1:0]   handle_reg,    handle_next;
    logic [IDX_W-1:0]   cur_reg,       cur_next;
    logic [LINK_W-1:0]  nxt_reg,       nxt_next;
    logic [LINK_W-1:0]  free_top_reg,  free_top_next;
    logic [LINK_W-1:0]  min_top_reg,   min_top_next;
    logic [IDX_W-1:0]   fs_pos_reg,    fs_pos_next;
    logic               fs_fresh_reg,  fs_fresh_next;
    logic [LINK_W-1:0]  head_reg [BUCKETS];
    logic [ENTRIES-1:0] live_reg;

    // Result and output registers
    logic [IDX_W-1:0]   res_entry_reg,  res_entry_next;
    status_t            res_status_reg, res_status_next;
    logic [COUNT_W-1:0] res_count_reg,  res_count_next;
    logic               out_valid_reg,  out_valid_next;
    logic [IDX_W-1:0]   out_entry_reg,  out_entry_next;
    status_t            out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg,  out_count_next;

    // Memory ports
    entry_word_t        ent_mem [ENTRIES];
    entry_word_t        ent_rd_reg;
    logic               ent_rd_en;
    logic [IDX_W-1:0]   ent_rd_addr;
    logic               ent_wr_en;
    logic [IDX_W-1:0]   ent_wr_addr;
    entry_word_t        ent_wr_data;

    logic [IDX_W-1:0]   fs_mem [ENTRIES];
    logic [IDX_W-1:0]   fs_rd_reg;
    logic               fs_rd_en;
    logic               fs_wr_en;
    logic [IDX_W-1:0]   fs_wr_addr;

    // Bucket heads and live flags write ports
    logic               head_we;
    logic [BKT_W-1:0]   head_waddr;
    logic [LINK_W-1:0]  head_wdata;
    logic               live_we;
    logic [IDX_W-1:0]   live_waddr;
    logic               live_wval;

    // Bucket index unit
    logic               hash_start;
    logic [KEY_W-1:0]   hash_key;
    logic               hash_done;
    logic [BKT_W-1:0]   hash_bucket;

    logic               accept;
    logic [LINK_W-1:0]  top_dec;
    logic [IDX_W-1:0]   alloc_idx;
    logic [LINK_W-1:0]  head_sel;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_dec;
    logic [LINK_W-1:0]  handle_link;
    logic [LINK_W-1:0]  cur_link;

    rht_bucket u_bucket (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (hash_key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign top_dec     = free_top_reg - LINK_W'(1);
    // Positions below the low-water mark were never pushed, so the power-up
    // order stands in for the memory read; it hands out entry 0 first.
    assign alloc_idx   = fs_fresh_reg ? (IDX_LAST - fs_pos_reg) : fs_rd_reg;
    assign head_sel    = head_reg[hash_bucket];
    assign count_inc   = (ent_rd_reg.count == COUNT_MAX) ? COUNT_MAX
                                                         : ent_rd_reg.count + COUNT_W'(1);
    assign count_dec   = ent_rd_reg.count - COUNT_W'(1);
    assign handle_link = {1'b0, handle_reg};
    assign cur_link    = {1'b0, cur_reg};

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        free_top_next   = free_top_reg;
        min_top_next    = min_top_reg;
        fs_pos_next     = fs_pos_reg;
        fs_fresh_next   = fs_fresh_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        ent_rd_en   = 1'b0;
        ent_rd_addr = handle;
        ent_wr_en   = 1'b0;
        ent_wr_addr = cur_reg;
        ent_wr_data = ent_rd_reg;
        fs_rd_en    = 1'b0;
        fs_wr_en    = 1'b0;
        fs_wr_addr  = free_top_reg[IDX_W-1:0];
        head_we     = 1'b0;
        head_waddr  = hash_bucket;
        head_wdata  = LINK_NULL;
        live_we     = 1'b0;
        live_waddr  = handle_reg;
        live_wval   = 1'b0;
        hash_start  = 1'b0;
        hash_key    = key;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = kind_t'(kind);
                    key_next    = key;
                    handle_next = handle;
                    case (kind_t'(kind))
                        KIND_ALLOC:
                        begin
                            if (free_top_reg == '0)
                            begin
                                res_entry_next  = '0;
                                res_status_next = ST_FULL;
                                res_count_next  = '0;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                fs_rd_en      = 1'b1;
                                fs_pos_next   = top_dec[IDX_W-1:0];
                                fs_fresh_next = (top_dec < min_top_reg);
                                hash_start    = 1'b1;
                                state_next    = S_HASH;
                            end
                        end
                        KIND_FIND:
                        begin
                            hash_start = 1'b1;
                            state_next = S_HASH;
                        end
                        KIND_REF, KIND_UNREF:
                        begin
                            ent_rd_en  = 1'b1;
                            state_next = S_HREAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        // Push the popped entry at the head of its bucket.
                        ent_wr_en         = 1'b1;
                        ent_wr_addr       = alloc_idx;
                        ent_wr_data.key   = key_reg;
                        ent_wr_data.count = COUNT_W'(1);
                        ent_wr_data.next  = head_sel;
                        head_we           = 1'b1;
                        head_wdata        = {1'b0, alloc_idx};
                        live_we           = 1'b1;
                        live_waddr        = alloc_idx;
                        live_wval         = 1'b1;
                        free_top_next     = top_dec;
                        if (top_dec < min_top_reg)
                        begin
                            min_top_next = top_dec;
                        end
                        res_entry_next  = alloc_idx;
                        res_status_next = ST_OK;
                        res_count_next  = COUNT_W'(1);
                        state_next      = S_DONE;
                    end
                    else if (head_sel == LINK_NULL)
                    begin
                        res_entry_next  = '0;
                        res_status_next = ST_NOT_FOUND;
                        res_count_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ent_rd_en   = 1'b1;
                        ent_rd_addr = head_sel[IDX_W-1:0];
                        cur_next    = head_sel[IDX_W-1:0];
                        state_next  = S_FIND;
                    end
                end
            end

            S_FIND:
            begin
                if (ent_rd_reg.key == key_reg)
                begin
                    ent_wr_en         = 1'b1;
                    ent_wr_data.count = count_inc;
                    res_entry_next    = cur_reg;
                    res_status_next   = ST_OK;
                    res_count_next    = count_inc;
                    state_next        = S_DONE;
                end
                else if (ent_rd_reg.next == LINK_NULL)
                begin
                    res_entry_next  = '0;
                    res_status_next = ST_NOT_FOUND;
                    res_count_next  = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = ent_rd_reg.next[IDX_W-1:0];
                    cur_next    = ent_rd_reg.next[IDX_W-1:0];
                end
            end

            S_HREAD:
            begin
                ent_wr_addr = handle_reg;
                if (!live_reg[handle_reg])
                begin
                    res_entry_next  = '0;
                    res_status_next = ST_BAD;
                    res_count_next  = '0;
                    state_next      = S_DONE;
                end
                else if (kind_reg == KIND_REF)
                begin
                    ent_wr_en         = 1'b1;
                    ent_wr_data.count = count_inc;
                    res_entry_next    = handle_reg;
                    res_status_next   = ST_OK;
                    res_count_next    = count_inc;
                    state_next        = S_DONE;
                end
                else if (count_dec != '0)
                begin
                    ent_wr_en         = 1'b1;
                    ent_wr_data.count = count_dec;
                    res_entry_next    = handle_reg;
                    res_status_next   = ST_OK;
                    res_count_next    = count_dec;
                    state_next        = S_DONE;
                end
                else
                begin
                    // Free now; unlink once the bucket of its key is known.
                    live_we    = 1'b1;
                    live_wval  = 1'b0;
                    if (free_top_reg < LINK_W'(ENTRIES))
                    begin
                        fs_wr_en      = 1'b1;
                        free_top_next = free_top_reg + LINK_W'(1);
                    end
                    nxt_next   = ent_rd_reg.next;
                    hash_start = 1'b1;
                    hash_key   = ent_rd_reg.key;
                    state_next = S_UNHASH;
                end
            end

            S_UNHASH:
            begin
                if (hash_done)
                begin
                    res_entry_next  = handle_reg;
                    res_status_next = ST_FREED;
                    res_count_next  = '0;
                    if (head_sel == handle_link)
                    begin
                        head_we    = 1'b1;
                        head_wdata = nxt_reg;
                        state_next = S_DONE;
                    end
                    else if (head_sel == LINK_NULL)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ent_rd_en   = 1'b1;
                        ent_rd_addr = head_sel[IDX_W-1:0];
                        cur_next    = head_sel[IDX_W-1:0];
                        state_next  = S_UNLINK;
                    end
                end
            end

            S_UNLINK:
            begin
                if (ent_rd_reg.next == handle_link)
                begin
                    // Bypass the freed entry from its predecessor.
                    ent_wr_en        = 1'b1;
                    ent_wr_data.next = nxt_reg;
                    state_next       = S_DONE;
                end
                else if ((ent_rd_reg.next == LINK_NULL) || (ent_rd_reg.next == cur_link))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = ent_rd_reg.next[IDX_W-1:0];
                    cur_next    = ent_rd_reg.next[IDX_W-1:0];
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_entry_next  = res_entry_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= KIND_ALLOC;
            key_reg        <= '0;
            handle_reg     <= '0;
            cur_reg        <= '0;
            nxt_reg        <= LINK_NULL;
            free_top_reg   <= LINK_W'(ENTRIES);
            min_top_reg    <= LINK_W'(ENTRIES);
            fs_pos_reg     <= '0;
            fs_fresh_reg   <= 1'b0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_reg[i] <= LINK_NULL;
            end
            live_reg       <= '0;
            res_entry_reg  <= '0;
            res_status_reg <= ST_OK;
            res_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_entry_reg  <= '0;
            out_status_reg <= ST_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            key_reg        <= key_next;
            handle_reg     <= handle_next;
            cur_reg        <= cur_next;
            nxt_reg        <= nxt_next;
            free_top_reg   <= free_top_next;
            min_top_reg    <= min_top_next;
            fs_pos_reg     <= fs_pos_next;
            fs_fresh_reg   <= fs_fresh_next;
            if (head_we)
            begin
                head_reg[head_waddr] <= head_wdata;
            end
            if (live_we)
            begin
                live_reg[live_waddr] <= live_wval;
            end
            res_entry_reg  <= res_entry_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= res_count_next;
            out_valid_reg  <= out_valid_next;
            out_entry_reg  <= out_entry_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    // Entry memory: key, count and link per entry, one read and one write port.
    always_ff @(posedge clk)
    begin
        if (ent_wr_en)
        begin
            ent_mem[ent_wr_addr] <= ent_wr_data;
        end
        if (ent_rd_en)
        begin
            ent_rd_reg <= ent_mem[ent_rd_addr];
        end
    end

    // Free stack memory: push the freed handle, pop from one below the top.
    always_ff @(posedge clk)
    begin
        if (fs_wr_en)
        begin
            fs_mem[fs_wr_addr] <= handle_reg;
        end
        if (fs_rd_en)
        begin
            fs_rd_reg <= fs_mem[top_dec[IDX_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign entry     = out_entry_reg;
    assign status    = out_status_reg;
    assign ref_count = out_count_reg;

endmodule

`default_nettype wire

>>> design/rht_checker.sv
// Port-level checks for the reference-counted hash table, bound to its top.
// Depends on rht_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rht_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rht_pkg::IDX_W-1:0]    entry,
    input logic [2:0]                   status,
    input logic [rht_pkg::COUNT_W-1:0]  ref_count
);
    import rht_pkg::*;

    // Hold a stalled result item.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(entry) && $stable(status) && $stable(ref_count), "result changed while stalled")

    // Drop ready after an accepted item: one item in work at a time.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready held after accept")

    `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && (status == ST_FULL || status == ST_NOT_FOUND || status == ST_BAD), entry == '0 && ref_count == '0, "failed request carries an entry or count")

    `ASSERT_IMPL(a_freed_zero, clk, rst_n, out_valid && status == ST_FREED, ref_count == '0, "freed entry reports a count")

    `ASSERT_IMPL(a_ok_live, clk, rst_n, out_valid && status == ST_OK, ref_count != '0, "ok result with zero count")

endmodule

bind refcounted_hash_table_top rht_checker u_rht_checker (.*);

`default_nettype wire
